/* hw/rtl/tdq_pkg.sv */
// tdq_pkg: shared constants, branch codes and pipeline side-band types
// for the transform decomposition block; no dependencies
`default_nettype none

package tdq_pkg;

    localparam int W         = 32;
    localparam int N_IN      = 12;
    localparam int N_OUT     = 10;
    localparam int IN_W      = W * N_IN;
    localparam int OUT_W     = W * N_OUT;
    localparam int QBITS     = 30;
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 62;
    localparam int ROW_QW    = 31;
    localparam int ROT_DW    = 33;
    localparam int ROT_QW    = 33;

    // which quaternion part comes from the quarter of k
    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    typedef struct packed {
        logic [8:0][W-1:0] b;
        logic [2:0]        zero;
        logic [8:0]        neg;
        logic [2:0][W-1:0] pos;
    } t_row_side;

    typedef struct packed {
        logic [2:0][W-1:0] scale;
        logic [2:0]        zero;
        logic [8:0]        neg;
        logic [2:0][W-1:0] pos;
    } t_div1_side;

    typedef struct packed {
        t_branch           br;
        logic [2:0][32:0]  num;
        logic [2:0][W-1:0] scale;
        logic [2:0][W-1:0] pos;
    } t_rot_side;

    typedef struct packed {
        t_branch           br;
        logic [30:0]       qtr;
        logic [2:0]        ovf;
        logic [2:0]        neg;
        logic              kz;
        logic [2:0][W-1:0] scale;
        logic [2:0][W-1:0] pos;
    } t_div2_side;

endpackage

`default_nettype wire

/* hw/rtl/transform_decompose_quaternion.sv */
// Decomposes the 3x3 block and translation of a row-vector affine transform into
// translation, a real-first Q2.30 quaternion and per-row Q16.16 scale. Fully
// pipelined: one transaction per cycle in and out, through the two 32-stage
// square-root pipelines and the 31- and 33-stage divider pipelines.
// A stall on the output freezes the whole pipeline. Uses tdq_pkg, tdq_sqrt, tdq_div.
`default_nettype none

module transform_decompose_quaternion (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // r0_x r0_y r0_z r1_x r1_y r1_z r2_x r2_y r2_z pos_x pos_y pos_z
    input  wire logic [tdq_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // trans_x trans_y trans_z quat_w quat_x quat_y quat_z scale_x scale_y scale_z
    output logic [tdq_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    localparam int W = tdq_pkg::W;
    localparam logic [W-1:0] QONE = W'(1) << tdq_pkg::QBITS;

    logic en;
    logic r_out_vld;
    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: magnitudes
    logic              r1_vld;
    logic [W-1:0]      r1_a [9];
    logic [8:0]        r1_neg;
    logic [2:0][W-1:0] r1_pos;
    logic [W-1:0]      n1_a [9];
    logic [8:0]        n1_neg;

    always_comb begin
        logic [W-1:0] m;
        for (int i = 0; i < 9; i++) begin
            m = i_s_axis_tdata[W*i +: W];
            n1_neg[i] = m[W-1];
            n1_a[i]   = m[W-1] ? (~m + W'(1)) : m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a   <= n1_a;
            r1_neg <= n1_neg;
            r1_pos <= i_s_axis_tdata[W*9 +: 3*W];
        end
    end

    // stage 2: squares and row maximum
    logic              r2_vld;
    logic [63:0]       r2_sq [9];
    logic [W-1:0]      r2_amax [3];
    logic [W-1:0]      r2_a [9];
    logic [8:0]        r2_neg;
    logic [2:0][W-1:0] r2_pos;
    logic [W-1:0]      n2_amax [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n2_amax[r] = r1_a[3*r];
            if (r1_a[3*r+1] > n2_amax[r]) n2_amax[r] = r1_a[3*r+1];
            if (r1_a[3*r+2] > n2_amax[r]) n2_amax[r] = r1_a[3*r+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) r2_sq[i] <= 64'(r1_a[i]) * 64'(r1_a[i]);
            r2_amax <= n2_amax;
            r2_a    <= r1_a;
            r2_neg  <= r1_neg;
            r2_pos  <= r1_pos;
        end
    end

    // stage 3: sums of squares and normalizing shift
    logic              r3_vld;
    logic [63:0]       r3_s [3];
    logic [4:0]        r3_p [3];
    logic [2:0]        r3_zero;
    logic [W-1:0]      r3_a [9];
    logic [8:0]        r3_neg;
    logic [2:0][W-1:0] r3_pos;
    logic [4:0]        n3_p [3];
    logic [2:0]        n3_zero;

    always_comb begin
        logic [4:0] h;
        for (int r = 0; r < 3; r++) begin
            h = '0;
            for (int b = 0; b < W; b++) begin
                if (r2_amax[r][b]) h = 5'(b);
            end
            n3_p[r]    = (h >= 5'd30) ? 5'd0 : (5'd30 - h);
            n3_zero[r] = (r2_amax[r] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r3_s[r] <= r2_sq[3*r] + r2_sq[3*r+1] + r2_sq[3*r+2];
            end
            r3_p    <= n3_p;
            r3_zero <= n3_zero;
            r3_a    <= r2_a;
            r3_neg  <= r2_neg;
            r3_pos  <= r2_pos;
        end
    end

    // stage 4: normalized magnitudes
    logic              r4_vld;
    logic [W-1:0]      r4_b [9];
    logic [63:0]       r4_s [3];
    logic [2:0]        r4_zero;
    logic [8:0]        r4_neg;
    logic [2:0][W-1:0] r4_pos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) r4_b[i] <= r3_a[i] << r3_p[i/3];
            r4_s    <= r3_s;
            r4_zero <= r3_zero;
            r4_neg  <= r3_neg;
            r4_pos  <= r3_pos;
        end
    end

    // stage 5: squares of normalized magnitudes
    logic              r5_vld;
    logic [63:0]       r5_bsq [9];
    logic [W-1:0]      r5_b [9];
    logic [63:0]       r5_s [3];
    logic [2:0]        r5_zero;
    logic [8:0]        r5_neg;
    logic [2:0][W-1:0] r5_pos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) r5_bsq[i] <= 64'(r4_b[i]) * 64'(r4_b[i]);
            r5_b    <= r4_b;
            r5_s    <= r4_s;
            r5_zero <= r4_zero;
            r5_neg  <= r4_neg;
            r5_pos  <= r4_pos;
        end
    end

    // stage 6: normalized sums
    logic              r6_vld;
    logic [63:0]       r6_sn [3];
    logic [W-1:0]      r6_b [9];
    logic [63:0]       r6_s [3];
    logic [2:0]        r6_zero;
    logic [8:0]        r6_neg;
    logic [2:0][W-1:0] r6_pos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r6_sn[r] <= r5_bsq[3*r] + r5_bsq[3*r+1] + r5_bsq[3*r+2];
            end
            r6_b    <= r5_b;
            r6_s    <= r5_s;
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
            r6_pos  <= r5_pos;
        end
    end

    // row lengths: lanes 0..2 normalized, lanes 3..5 scale
    logic [5:0][63:0]                  sqa_val;
    tdq_pkg::t_row_side                sqa_side_in;
    tdq_pkg::t_row_side                sqa_side;
    logic                              sqa_vld;
    logic [5:0][tdq_pkg::ROOT_W-1:0]   sqa_root;
    logic [5:0][tdq_pkg::ROOT_W+1:0]   sqa_rem;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sqa_val[r]   = r6_sn[r];
            sqa_val[r+3] = r6_s[r];
        end
        for (int i = 0; i < 9; i++) sqa_side_in.b[i] = r6_b[i];
        sqa_side_in.zero = r6_zero;
        sqa_side_in.neg  = r6_neg;
        sqa_side_in.pos  = r6_pos;
    end

    tdq_sqrt #(
        .LANES (6),
        .RW    (tdq_pkg::ROOT_W),
        .SW    ($bits(tdq_pkg::t_row_side))
    ) u_sqrt_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r6_vld),
        .i_val   (sqa_val),
        .i_side  (sqa_side_in),
        .o_vld   (sqa_vld),
        .o_root  (sqa_root),
        .o_rem   (sqa_rem),
        .o_side  (sqa_side)
    );

    // stage 7: scale rounding and division operands
    logic                                     r7_vld;
    logic [8:0][tdq_pkg::NUM_W-1:0]           r7_num;
    logic [8:0][W-1:0]                        r7_den;
    tdq_pkg::t_div1_side                      r7_side;
    logic [8:0][tdq_pkg::NUM_W-1:0]           n7_num;
    logic [8:0][W-1:0]                        n7_den;
    tdq_pkg::t_div1_side                      n7_side;

    always_comb begin
        logic [W-1:0] root;
        logic         inc;
        for (int r = 0; r < 3; r++) begin
            root = sqa_root[r+3];
            inc  = (sqa_rem[r+3] > {2'b00, root}) && (root != '1);
            n7_side.scale[r] = root + W'(inc);
        end
        for (int i = 0; i < 9; i++) begin
            n7_num[i] = {sqa_side.b[i], 30'd0} + tdq_pkg::NUM_W'(sqa_root[i/3] >> 1);
            n7_den[i] = sqa_root[i/3];
        end
        n7_side.zero = sqa_side.zero;
        n7_side.neg  = sqa_side.neg;
        n7_side.pos  = sqa_side.pos;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num  <= n7_num;
            r7_den  <= n7_den;
            r7_side <= n7_side;
        end
    end

    logic                                dva_vld;
    logic [8:0][tdq_pkg::ROW_QW-1:0]     dva_quo;
    tdq_pkg::t_div1_side                 dva_side;

    tdq_div #(
        .LANES (9),
        .NW    (tdq_pkg::NUM_W),
        .DW    (W),
        .QW    (tdq_pkg::ROW_QW),
        .SW    ($bits(tdq_pkg::t_div1_side))
    ) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r7_vld),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_vld   (dva_vld),
        .o_quo   (dva_quo),
        .o_side  (dva_side)
    );

    // stage 8: rotation entries, index row*3+col
    logic                  r8_vld;
    logic signed [W-1:0]   r8_e [9];
    logic [2:0][W-1:0]     r8_scale;
    logic [2:0][W-1:0]     r8_pos;
    logic signed [W-1:0]   n8_e [9];

    always_comb begin
        logic [tdq_pkg::ROW_QW-1:0] qc;
        for (int i = 0; i < 9; i++) begin
            qc = (dva_quo[i] > tdq_pkg::ROW_QW'(QONE)) ? tdq_pkg::ROW_QW'(QONE) : dva_quo[i];
            if (dva_side.zero[i/3]) begin
                n8_e[i] = ((i % 3) == (i / 3)) ? QONE : '0;
            end else if (dva_side.neg[i]) begin
                n8_e[i] = ~W'(qc) + W'(1);
            end else begin
                n8_e[i] = W'(qc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_e     <= n8_e;
            r8_scale <= dva_side.scale;
            r8_pos   <= dva_side.pos;
        end
    end

    // stage 9: trace, comparisons and candidate sums
    logic signed [W-1:0] R00, R01, R02, R10, R11, R12, R20, R21, R22;
    assign R00 = r8_e[0];
    assign R01 = r8_e[3];
    assign R02 = r8_e[6];
    assign R10 = r8_e[1];
    assign R11 = r8_e[4];
    assign R12 = r8_e[7];
    assign R20 = r8_e[2];
    assign R21 = r8_e[5];
    assign R22 = r8_e[8];

    localparam logic signed [34:0] QONE35 = 35'(QONE);

    logic                 r9_vld;
    logic signed [33:0]   r9_tr;
    logic                 r9_c1;
    logic                 r9_c2;
    logic signed [32:0]   r9_d21, r9_d02, r9_d10, r9_s01, r9_s02, r9_s12;
    logic signed [34:0]   r9_radt, r9_rad0, r9_rad1, r9_rad2;
    logic [2:0][W-1:0]    r9_scale;
    logic [2:0][W-1:0]    r9_pos;
    logic signed [33:0]   n9_tr;

    assign n9_tr = 34'(R00) + 34'(R11) + 34'(R22);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_tr    <= n9_tr;
            r9_c1    <= (R00 > R11) && (R00 > R22);
            r9_c2    <= (R11 > R22);
            r9_d21   <= 33'(R21) - 33'(R12);
            r9_d02   <= 33'(R02) - 33'(R20);
            r9_d10   <= 33'(R10) - 33'(R01);
            r9_s01   <= 33'(R01) + 33'(R10);
            r9_s02   <= 33'(R02) + 33'(R20);
            r9_s12   <= 33'(R12) + 33'(R21);
            r9_radt  <= 35'(n9_tr) + QONE35;
            r9_rad0  <= QONE35 + 35'(R00) - 35'(R11) - 35'(R22);
            r9_rad1  <= QONE35 + 35'(R11) - 35'(R00) - 35'(R22);
            r9_rad2  <= QONE35 + 35'(R22) - 35'(R00) - 35'(R11);
            r9_scale <= r8_scale;
            r9_pos   <= r8_pos;
        end
    end

    // stage 10: branch selection
    logic                 r10_vld;
    logic [32:0]          r10_rad;
    tdq_pkg::t_rot_side   r10_side;
    logic signed [34:0]   n10_rad;
    tdq_pkg::t_rot_side   n10_side;

    always_comb begin
        n10_side.scale = r9_scale;
        n10_side.pos   = r9_pos;
        priority if (r9_tr > 34'sd0) begin
            n10_side.br  = tdq_pkg::BR_W;
            n10_rad      = r9_radt;
            n10_side.num = {r9_d10, r9_d02, r9_d21};
        end else if (r9_c1) begin
            n10_side.br  = tdq_pkg::BR_X;
            n10_rad      = r9_rad0;
            n10_side.num = {r9_s02, r9_s01, r9_d21};
        end else if (r9_c2) begin
            n10_side.br  = tdq_pkg::BR_Y;
            n10_rad      = r9_rad1;
            n10_side.num = {r9_s12, r9_s01, r9_d02};
        end else begin
            n10_side.br  = tdq_pkg::BR_Z;
            n10_rad      = r9_rad2;
            n10_side.num = {r9_s12, r9_s02, r9_d10};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_rad  <= n10_rad[34] ? '0 : n10_rad[32:0];
            r10_side <= n10_side;
        end
    end

    logic [0:0][63:0]                  sqb_val;
    logic                              sqb_vld;
    logic [0:0][tdq_pkg::ROOT_W-1:0]   sqb_root;
    logic [0:0][tdq_pkg::ROOT_W+1:0]   sqb_rem;
    tdq_pkg::t_rot_side                sqb_side;

    assign sqb_val[0] = {1'b0, r10_rad, 30'd0};

    tdq_sqrt #(
        .LANES (1),
        .RW    (tdq_pkg::ROOT_W),
        .SW    ($bits(tdq_pkg::t_rot_side))
    ) u_sqrt_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r10_vld),
        .i_val   (sqb_val),
        .i_side  (r10_side),
        .o_vld   (sqb_vld),
        .o_root  (sqb_root),
        .o_rem   (sqb_rem),
        .o_side  (sqb_side)
    );

    // stage 11: k, quarter of k and quotient numerators
    logic                             r11_vld;
    logic [33:0]                      r11_k;
    logic [30:0]                      r11_qtr;
    logic [2:0][tdq_pkg::NUM_W-1:0]   r11_n;
    logic [2:0]                       r11_neg;
    tdq_pkg::t_branch                 r11_br;
    logic [2:0][W-1:0]                r11_scale;
    logic [2:0][W-1:0]                r11_pos;
    logic [33:0]                      n11_k;
    logic [33:0]                      n11_k2;
    logic [2:0][tdq_pkg::NUM_W-1:0]   n11_n;
    logic [2:0]                       n11_neg;

    always_comb begin
        logic [32:0] rr;
        logic [32:0] mag;
        rr      = {1'b0, sqb_root[0]} + 33'(sqb_rem[0] > {2'b00, sqb_root[0]});
        n11_k   = {rr, 1'b0};
        n11_k2  = n11_k + 34'd2;
        for (int j = 0; j < 3; j++) begin
            n11_neg[j] = sqb_side.num[j][32];
            mag = sqb_side.num[j][32] ? (~sqb_side.num[j] + 33'd1) : sqb_side.num[j];
            n11_n[j] = {mag[31:0], 30'd0} + tdq_pkg::NUM_W'(n11_k >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_k     <= n11_k;
            r11_qtr   <= n11_k2[32:2];
            r11_n     <= n11_n;
            r11_neg   <= n11_neg;
            r11_br    <= sqb_side.br;
            r11_scale <= sqb_side.scale;
            r11_pos   <= sqb_side.pos;
        end
    end

    // stage 12: overflow and zero-divisor checks
    logic                             r12_vld;
    logic [2:0][tdq_pkg::NUM_W-1:0]   r12_n;
    logic [2:0][tdq_pkg::ROT_DW-1:0]  r12_k;
    tdq_pkg::t_div2_side              r12_side;
    tdq_pkg::t_div2_side              n12_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n12_side.ovf[j] = (66'(r11_n[j]) >= {r11_k[32:0], 33'd0});
        end
        n12_side.br    = r11_br;
        n12_side.qtr   = r11_qtr;
        n12_side.neg   = r11_neg;
        n12_side.kz    = (r11_k == '0);
        n12_side.scale = r11_scale;
        n12_side.pos   = r11_pos;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_n    <= r11_n;
            for (int j = 0; j < 3; j++) r12_k[j] <= r11_k[32:0];
            r12_side <= n12_side;
        end
    end

    logic                                dvb_vld;
    logic [2:0][tdq_pkg::ROT_QW-1:0]     dvb_quo;
    tdq_pkg::t_div2_side                 dvb_side;

    tdq_div #(
        .LANES (3),
        .NW    (tdq_pkg::NUM_W),
        .DW    (tdq_pkg::ROT_DW),
        .QW    (tdq_pkg::ROT_QW),
        .SW    ($bits(tdq_pkg::t_div2_side))
    ) u_div_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r12_vld),
        .i_num   (r12_n),
        .i_den   (r12_k),
        .i_side  (r12_side),
        .o_vld   (dvb_vld),
        .o_quo   (dvb_quo),
        .o_side  (dvb_side)
    );

    // stage 13: saturation, routing and output register
    logic [tdq_pkg::OUT_W-1:0] r_out_data;
    logic [tdq_pkg::OUT_W-1:0] n_out_data;

    always_comb begin
        logic [W-1:0] lane [3];
        logic [W-1:0] qtr;
        logic [W-1:0] qw, qx, qy, qz;
        logic [tdq_pkg::ROT_QW-1:0] q;
        for (int j = 0; j < 3; j++) begin
            q = dvb_quo[j];
            if (dvb_side.kz) begin
                lane[j] = '0;
            end else if (dvb_side.neg[j]) begin
                if (dvb_side.ovf[j] || (q > 33'h0_8000_0000)) lane[j] = 32'h8000_0000;
                else lane[j] = ~q[W-1:0] + W'(1);
            end else begin
                if (dvb_side.ovf[j] || (q > 33'h0_7FFF_FFFF)) lane[j] = 32'h7FFF_FFFF;
                else lane[j] = q[W-1:0];
            end
        end
        qtr = {1'b0, dvb_side.qtr};
        unique case (dvb_side.br)
            tdq_pkg::BR_W: begin
                qw = qtr;     qx = lane[0]; qy = lane[1]; qz = lane[2];
            end
            tdq_pkg::BR_X: begin
                qw = lane[0]; qx = qtr;     qy = lane[1]; qz = lane[2];
            end
            tdq_pkg::BR_Y: begin
                qw = lane[0]; qx = lane[1]; qy = qtr;     qz = lane[2];
            end
            default: begin
                qw = lane[0]; qx = lane[1]; qy = lane[2]; qz = qtr;
            end
        endcase
        n_out_data = {dvb_side.scale, qz, qy, qx, qw, dvb_side.pos};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    // valid chain for the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r11_vld   <= 1'b0;
            r12_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_s_axis_tvalid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= sqa_vld;
            r8_vld    <= dva_vld;
            r9_vld    <= r8_vld;
            r10_vld   <= r9_vld;
            r11_vld   <= sqb_vld;
            r12_vld   <= r11_vld;
            r_out_vld <= dvb_vld;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* hw/rtl/tdq_sqrt.sv */
// tdq_sqrt: multi-lane pipelined integer square root, one root bit per stage,
// gives floor root and remainder; side-band and valid travel alongside
`default_nettype none

module tdq_sqrt #(
    parameter int LANES = 1,
    parameter int RW    = 32,
    parameter int SW    = 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_vld,
    input  wire logic [LANES-1:0][2*RW-1:0]       i_val,
    input  wire logic [SW-1:0]                    i_side,
    output logic                                  o_vld,
    output logic      [LANES-1:0][RW-1:0]         o_root,
    output logic      [LANES-1:0][RW+1:0]         o_rem,
    output logic      [SW-1:0]                    o_side
);

    logic [LANES-1:0][2*RW-1:0] r_v    [RW];
    logic [LANES-1:0][RW+1:0]   r_rem  [RW];
    logic [LANES-1:0][RW-1:0]   r_root [RW];
    logic [SW-1:0]              r_side [RW];
    logic                       r_vld  [RW];

    for (genvar st = 0; st < RW; st++) begin : g_st
        logic [LANES-1:0][2*RW-1:0] s_v;
        logic [LANES-1:0][RW+1:0]   s_rem;
        logic [LANES-1:0][RW-1:0]   s_root;
        logic [SW-1:0]              s_side;
        logic                       s_vld;
        logic [LANES-1:0][2*RW-1:0] n_v;
        logic [LANES-1:0][RW+1:0]   n_rem;
        logic [LANES-1:0][RW-1:0]   n_root;

        if (st == 0) begin : g_first
            assign s_v    = i_val;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_side = i_side;
            assign s_vld  = i_vld;
        end else begin : g_next
            assign s_v    = r_v[st-1];
            assign s_rem  = r_rem[st-1];
            assign s_root = r_root[st-1];
            assign s_side = r_side[st-1];
            assign s_vld  = r_vld[st-1];
        end

        always_comb begin
            logic [RW+1:0] sh;
            logic [RW+1:0] trial;
            logic          ge;
            for (int ln = 0; ln < LANES; ln++) begin
                sh    = {s_rem[ln][RW-1:0], s_v[ln][2*RW-1:2*RW-2]};
                trial = {1'b0, s_root[ln][RW-2:0], 2'b01};
                ge    = (sh >= trial);
                n_rem[ln]  = ge ? (sh - trial) : sh;
                n_root[ln] = {s_root[ln][RW-2:0], ge};
                n_v[ln]    = {s_v[ln][2*RW-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[st] <= 1'b0;
            end else if (i_en) begin
                r_vld[st] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[st]    <= n_v;
                r_rem[st]  <= n_rem;
                r_root[st] <= n_root;
                r_side[st] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_rem  = r_rem[RW-1];
    assign o_side = r_side[RW-1];

endmodule

`default_nettype wire

/* hw/rtl/tdq_div.sv */
// tdq_div: multi-lane pipelined restoring divider, one quotient bit per stage;
// caller guarantees the quotient fits QW bits; side-band travels alongside
`default_nettype none

module tdq_div #(
    parameter int LANES = 1,
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int SW    = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [LANES-1:0][NW-1:0]   i_num,
    input  wire logic [LANES-1:0][DW-1:0]   i_den,
    input  wire logic [SW-1:0]              i_side,
    output logic                            o_vld,
    output logic      [LANES-1:0][QW-1:0]   o_quo,
    output logic      [SW-1:0]              o_side
);

    logic [LANES-1:0][DW-1:0] r_rem  [QW];
    logic [LANES-1:0][DW-1:0] r_den  [QW];
    logic [LANES-1:0][QW-1:0] r_lo   [QW];
    logic [LANES-1:0][QW-1:0] r_quo  [QW];
    logic [SW-1:0]            r_side [QW];
    logic                     r_vld  [QW];

    for (genvar st = 0; st < QW; st++) begin : g_st
        logic [LANES-1:0][DW-1:0] s_rem;
        logic [LANES-1:0][DW-1:0] s_den;
        logic [LANES-1:0][QW-1:0] s_lo;
        logic [LANES-1:0][QW-1:0] s_quo;
        logic [SW-1:0]            s_side;
        logic                     s_vld;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_lo;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (st == 0) begin : g_first
            always_comb begin
                for (int ln = 0; ln < LANES; ln++) begin
                    s_rem[ln] = DW'(i_num[ln][NW-1:QW]);
                    s_lo[ln]  = i_num[ln][QW-1:0];
                end
            end
            assign s_den  = i_den;
            assign s_quo  = '0;
            assign s_side = i_side;
            assign s_vld  = i_vld;
        end else begin : g_next
            assign s_rem  = r_rem[st-1];
            assign s_den  = r_den[st-1];
            assign s_lo   = r_lo[st-1];
            assign s_quo  = r_quo[st-1];
            assign s_side = r_side[st-1];
            assign s_vld  = r_vld[st-1];
        end

        always_comb begin
            logic [DW:0] sh;
            logic [DW:0] diff;
            logic        ge;
            for (int ln = 0; ln < LANES; ln++) begin
                sh    = {s_rem[ln], s_lo[ln][QW-1]};
                diff  = sh - {1'b0, s_den[ln]};
                ge    = (sh >= {1'b0, s_den[ln]});
                n_rem[ln] = ge ? diff[DW-1:0] : sh[DW-1:0];
                n_quo[ln] = {s_quo[ln][QW-2:0], ge};
                n_lo[ln]  = {s_lo[ln][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[st] <= 1'b0;
            end else if (i_en) begin
                r_vld[st] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[st]  <= n_rem;
                r_den[st]  <= s_den;
                r_lo[st]   <= n_lo;
                r_quo[st]  <= n_quo;
                r_side[st] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

`default_nettype wire
